FILE: design/capm_pkg.sv
// Package with the shared constants and the fixed pattern table of the crawler pattern matcher.
`timescale 1ns / 1ps

package capm_pkg;

    localparam int WINDOW_BYTES_DEFAULT = 16;
    localparam int BYTE_W               = 8;
    localparam int IN_TDATA_W           = 8;
    localparam int OUT_TDATA_W          = 8;
    localparam int PAT_COUNT            = 19;
    localparam int PAT_MAX_LEN          = 16;

    // Each pattern is right-justified: its last character sits in bits [7:0].
    localparam logic [PAT_MAX_LEN*BYTE_W-1:0] PAT_TEXT [PAT_COUNT] = '{
        "bot.htm",
        "bot@",
        "ysearch",
        "bot.php",
        "MJ12bot/",
        "webspider.htm",
        "+crawler",
        "crawler@",
        "crawlerinfo.html",
        "/robot",
        "/bots",
        "/crawler.",
        "Applebot",
        {"Word", "Press/"},
        "pingback",
        "adscanner",
        "DotBot",
        "serpstatbot",
        "AspiegelBot"
    };

    localparam int PAT_LEN [PAT_COUNT] = '{
        7, 4, 7, 7, 8, 13, 8, 8, 16, 6, 5, 9, 8, 10, 8, 9, 6, 11, 11
    };

endpackage

FILE: design/capm_match.sv
// Parallel comparator that flags any fixed pattern ending at the newest byte of the line.
`timescale 1ns / 1ps

module capm_match #(
    parameter int WINDOW_BYTES = capm_pkg::WINDOW_BYTES_DEFAULT
) (
    input  logic [WINDOW_BYTES-1:0][capm_pkg::BYTE_W-1:0] line,
    output logic                                          hit
);
    import capm_pkg::*;

    logic [PAT_COUNT-1:0] pat_hit;

    // Byte zero of the line is the newest byte, so each pattern is compared end-aligned.
    for (genvar k = 0; k < PAT_COUNT; k++)
    begin : g_pat
        if (PAT_LEN[k] <= WINDOW_BYTES)
        begin : g_fits
            logic [PAT_LEN[k]-1:0] byte_eq;
            for (genvar j = 0; j < PAT_LEN[k]; j++)
            begin : g_byte
                assign byte_eq[j] = (line[j] == PAT_TEXT[k][BYTE_W*j +: BYTE_W]);
            end
            assign pat_hit[k] = &byte_eq;
        end
        else
        begin : g_too_long
            assign pat_hit[k] = 1'b0;
        end
    end

    assign hit = |pat_hit;

endmodule

FILE: design/crawler_agent_pattern_matcher_unit.sv
// Top level of the crawler pattern matcher: input register, byte history, match and result register.
`timescale 1ns / 1ps

// The block takes a string one byte per word and answers every word with one result word, at a
// sustained rate of one word per clock while m_axis_tready holds; the history shift and the parallel
// pattern compare sit between the input register and the result register. The result carries
// a sticky found flag in tdata bit 0, and tlast marks the verdict for the string that closed
// with a tlast input word. After that word the byte history and the flag clear.
module crawler_agent_pattern_matcher_unit #(
    parameter int WINDOW_BYTES = capm_pkg::WINDOW_BYTES_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [capm_pkg::IN_TDATA_W-1:0]     s_axis_tdata,   // [7:0] char_byte
    input  logic                                s_axis_tlast,   // is_final
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [capm_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,   // [0] found, [7:1] zero
    output logic                                m_axis_tlast    // verdict_valid
);
    import capm_pkg::*;

    localparam int HIST_BYTES = WINDOW_BYTES - 1;

    logic                                  in_valid_reg;
    logic                                  in_valid_next;
    logic [BYTE_W-1:0]                     in_byte_reg;
    logic                                  in_final_reg;
    logic [HIST_BYTES-1:0][BYTE_W-1:0]     hist_reg;
    logic [HIST_BYTES-1:0][BYTE_W-1:0]     hist_next;
    logic                                  found_reg;
    logic                                  found_next;
    logic                                  out_valid_reg;
    logic                                  out_valid_next;
    logic                                  out_found_reg;
    logic                                  out_last_reg;
    logic [WINDOW_BYTES-1:0][BYTE_W-1:0]   line;
    logic                                  hit;
    logic                                  found_now;
    logic                                  advance;
    logic                                  in_accept;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    assign line      = {hist_reg, in_byte_reg};
    assign found_now = found_reg | hit;

    capm_match #(
        .WINDOW_BYTES (WINDOW_BYTES)
    ) u_match (
        .line (line),
        .hit  (hit)
    );

    always_comb
    begin
        in_valid_next  = in_valid_reg;
        hist_next      = hist_reg;
        found_next     = found_reg;
        out_valid_next = out_valid_reg;
        if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (advance)
        begin
            out_valid_next = 1'b1;
            in_valid_next  = 1'b0;
            if (in_final_reg)
            begin
                hist_next  = '0;
                found_next = 1'b0;
            end
            else
            begin
                hist_next  = {hist_reg[HIST_BYTES-2:0], in_byte_reg};
                found_next = found_now;
            end
        end
        if (in_accept)
        begin
            in_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            hist_reg      <= '0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            hist_reg      <= hist_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_byte_reg  <= s_axis_tdata[BYTE_W-1:0];
            in_final_reg <= s_axis_tlast;
        end
        if (advance)
        begin
            out_found_reg <= found_now;
            out_last_reg  <= in_final_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_W-1){1'b0}}, out_found_reg};
    assign m_axis_tlast  = out_last_reg;

endmodule

FILE: test/crawler_agent_pattern_matcher_unit_test.sv
// Self-checking testbench that streams random and directed strings through the crawler pattern matcher.
`timescale 1ns / 1ps

module crawler_agent_pattern_matcher_unit_test;

    import capm_pkg::*;

    localparam int TAG_COUNT   = 19;
    localparam int CYCLE_LIMIT = 200000;
    localparam int FEED_PHASE  = 620;

    // Patterns are right-justified: the last character sits in the low byte.
    localparam logic [127:0] AGENT_TAGS [TAG_COUNT] = '{
        "bot.htm", "bot@", "ysearch", "bot.php", "MJ12bot/",
        "webspider.htm", "+crawler", "crawler@", "crawlerinfo.html", "/robot",
        "/bots", "/crawler.", "Applebot", {"Word", "Press/"}, "pingback",
        "adscanner", "DotBot", "serpstatbot", "AspiegelBot"
    };

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } text_byte_t;

    typedef struct packed {
        logic found;
        logic closes;
    } match_word_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   s_axis_tlast = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tlast;

    text_byte_t  byte_feed [$];
    match_word_t verdict_queue [$];
    logic [7:0]  text_buf [$];

    logic [119:0] seen_bytes = '0;
    logic         seen_flag = 1'b0;

    int send_idle_pct = 25;
    int take_idle_pct = 63;
    int queued_items = 0;
    int fail_count = 0;
    int cycle_count = 0;

    crawler_agent_pattern_matcher_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 clk = ~clk;

    function automatic int tag_len(input logic [127:0] tag);
        int n;
        n = 0;
        while (n < 16 && tag[8*n +: 8] != 8'h00)
            n++;
        return n;
    endfunction

    function automatic logic tag_hit(input logic [127:0] line);
        logic [127:0] mask;
        logic         hit;
        int           n;
        hit = 1'b0;
        for (int k = 0; k < TAG_COUNT; k++) begin
            n = tag_len(AGENT_TAGS[k]);
            mask = (n >= 16) ? '1 : ((128'd1 << (8 * n)) - 128'd1);
            if ((line & mask) == AGENT_TAGS[k])
                hit = 1'b1;
        end
        return hit;
    endfunction

    function automatic match_word_t predict_verdict(input logic [7:0] ch, input logic fin);
        logic [127:0] line;
        match_word_t  w;
        line = {seen_bytes, ch};
        w.found = seen_flag | tag_hit(line);
        w.closes = fin;
        if (fin) begin
            seen_bytes = '0;
            seen_flag = 1'b0;
        end
        else begin
            seen_bytes = line[119:0];
            seen_flag = w.found;
        end
        return w;
    endfunction

    task automatic queue_byte(input logic [7:0] ch, input logic fin);
        text_byte_t b;
        b.ch = ch;
        b.last = fin;
        byte_feed.push_back(b);
        queued_items++;
    endtask

    task automatic queue_literal(input string s, input logic fin);
        for (int i = 0; i < s.len(); i++)
            queue_byte(s[i], fin && (i == s.len() - 1));
    endtask

    task automatic flush_text();
        if (text_buf.size() == 0)
            text_buf.push_back(8'($urandom_range(0, 255)));
        foreach (text_buf[i])
            queue_byte(text_buf[i], i == text_buf.size() - 1);
        text_buf.delete();
    endtask

    task automatic append_tag_chars(input int k, input int first, input int count);
        int n;
        n = tag_len(AGENT_TAGS[k]);
        for (int i = first; i < first + count; i++)
            text_buf.push_back(AGENT_TAGS[k][8*(n-1-i) +: 8]);
    endtask

    task automatic append_filler(input int count);
        int k;
        int n;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 1) == 0) begin
                text_buf.push_back(8'($urandom_range(0, 255)));
            end
            else begin
                k = $urandom_range(0, TAG_COUNT - 1);
                n = tag_len(AGENT_TAGS[k]);
                text_buf.push_back(AGENT_TAGS[k][8*$urandom_range(0, n-1) +: 8]);
            end
        end
    endtask

    // Most strings carry a whole pattern; the rest carry near misses, a pattern split over
    // two strings, or plain noise.
    task automatic queue_random_text();
        int kind;
        int k;
        int k2;
        int n;
        int cut;
        int p;
        kind = $urandom_range(0, 9);
        k = $urandom_range(0, TAG_COUNT - 1);
        n = tag_len(AGENT_TAGS[k]);
        append_filler($urandom_range(0, 12));
        if (kind <= 5) begin
            append_tag_chars(k, 0, n);
            if (kind == 5) begin
                append_filler($urandom_range(0, 4));
                k2 = $urandom_range(0, TAG_COUNT - 1);
                append_tag_chars(k2, 0, tag_len(AGENT_TAGS[k2]));
            end
        end
        else if (kind == 6) begin
            append_tag_chars(k, 0, n);
            p = text_buf.size() - 1 - $urandom_range(0, n - 1);
            text_buf[p] = text_buf[p] ^ 8'h20;
        end
        else if (kind == 7) begin
            append_tag_chars(k, 1, n - 1);
        end
        else if (kind == 8) begin
            cut = $urandom_range(1, n - 1);
            append_tag_chars(k, 0, cut);
            flush_text();
            append_tag_chars(k, cut, n - cut);
        end
        append_filler($urandom_range(0, 12));
        flush_text();
    endtask

    always @(posedge clk or negedge rst_n) begin
        text_byte_t b;
        if (!rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
            s_axis_tlast <= 1'b0;
        end
        else if (!s_axis_tvalid || s_axis_tready) begin
            if (s_axis_tvalid)
                verdict_queue.push_back(predict_verdict(s_axis_tdata[7:0], s_axis_tlast));
            if (byte_feed.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                b = byte_feed.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= b.ch;
                s_axis_tlast <= b.last;
            end
            else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n) begin
        match_word_t w;
        if (!rst_n) begin
            m_axis_tready <= 1'b0;
        end
        else begin
            m_axis_tready <= ($urandom_range(0, 99) >= take_idle_pct);
            if (m_axis_tvalid && m_axis_tready) begin
                if (verdict_queue.size() == 0) begin
                    $display("%0t: unexpected word, expected none, actual tdata=%h tlast=%b",
                             $time, m_axis_tdata, m_axis_tlast);
                    fail_count++;
                end
                else begin
                    w = verdict_queue.pop_front();
                    if (m_axis_tdata[0] !== w.found) begin
                        $display("%0t: found mismatch, expected %b, actual %b",
                                 $time, w.found, m_axis_tdata[0]);
                        fail_count++;
                    end
                    if (m_axis_tdata[OUT_TDATA_W-1:1] !== '0) begin
                        $display("%0t: tdata padding mismatch, expected 0, actual %h",
                                 $time, m_axis_tdata[OUT_TDATA_W-1:1]);
                        fail_count++;
                    end
                    if (m_axis_tlast !== w.closes) begin
                        $display("%0t: tlast mismatch, expected %b, actual %b",
                                 $time, w.closes, m_axis_tlast);
                        fail_count++;
                    end
                end
            end
        end
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("crawler_agent_pattern_matcher_unit verification failed");
            $finish;
        end
    end

    initial begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        for (int phase = 0; phase < 3; phase++) begin
            if (phase == 0) begin
                send_idle_pct = 25;
                take_idle_pct = 63;
                queue_literal("bot@", 1'b1);
                queue_byte(8'h00, 1'b1);
                queue_byte(8'hFF, 1'b1);
                queue_literal("bot.h", 1'b1);
                queue_literal("tm", 1'b1);
                queue_literal("bot", 1'b0);
                queue_byte(8'h00, 1'b0);
                queue_literal("@", 1'b1);
                queue_literal("xBot@", 1'b1);
            end
            else if (phase == 1) begin
                send_idle_pct = 63;
                take_idle_pct = 25;
            end
            else begin
                send_idle_pct = 0;
                take_idle_pct = 0;
            end
            while (queued_items < FEED_PHASE * (phase + 1))
                queue_random_text();
            @(negedge clk);
            while (byte_feed.size() > 0 || s_axis_tvalid || verdict_queue.size() > 0)
                @(negedge clk);
        end

        repeat (20) @(posedge clk);
        if (fail_count == 0 && verdict_queue.size() == 0)
            $display("crawler_agent_pattern_matcher_unit verification clean");
        else
            $display("crawler_agent_pattern_matcher_unit verification failed");
        $finish;
    end

endmodule
